/* design/axrot_pkg.sv */
// axrot_pkg: shared types, action codes and CORDIC constants for the axis rotation block.
// No dependencies; imported by axrot_cordic and axis_rotation_3d.
package axrot_pkg;

  localparam int CordicStages = 24;

  // gain-compensated 1.0 in Q2.30
  localparam logic signed [32:0] CORDIC_ONE = 33'sd652032874;

  localparam logic [1:0] ACT_ROLL  = 2'd0;
  localparam logic [1:0] ACT_PITCH = 2'd1;
  localparam logic [1:0] ACT_YAW   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  typedef struct packed {
    logic [1:0] action;
    vtx_t       vtx;
  } side_t;

  // arctangent of 2^-i, 2^32 units per turn, rounded
  function automatic logic signed [31:0] atan_lut(input int idx);
    logic signed [31:0] v;
    begin
      unique case (idx)
        0:  v = 32'sd536870912;
        1:  v = 32'sd316933406;
        2:  v = 32'sd167458907;
        3:  v = 32'sd85004756;
        4:  v = 32'sd42667331;
        5:  v = 32'sd21354465;
        6:  v = 32'sd10679838;
        7:  v = 32'sd5340245;
        8:  v = 32'sd2670163;
        9:  v = 32'sd1335087;
        10: v = 32'sd667544;
        11: v = 32'sd333772;
        12: v = 32'sd166886;
        13: v = 32'sd83443;
        14: v = 32'sd41722;
        15: v = 32'sd20861;
        16: v = 32'sd10430;
        17: v = 32'sd5215;
        18: v = 32'sd2608;
        19: v = 32'sd1304;
        20: v = 32'sd652;
        21: v = 32'sd326;
        22: v = 32'sd163;
        23: v = 32'sd81;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* design/axis_rotation_3d.sv */
// axis_rotation_3d: top level, rotates one Q16.16 vertex about x, y or z per request.
// Depends on axrot_pkg and axrot_cordic.

// One request in, one rotated vertex out, one request per clock when the output is not
// stalled. From acceptance to out_valid a request passes a fold stage, 24 CORDIC
// stages (one iteration each), a quadrant unfold stage, a multiply stage (four 32x32
// products), a sum/round stage, a saturate stage and the output register. The whole
// pipeline advances together; an output register backed by a one-entry skid buffer lets
// a new request in while a finished vertex waits, and in_stall is taken straight from
// the skid flag (registered), rising only once the output and the skid are both held.
// The angle is negated before use; action 3 passes the vertex through unchanged.
// Rotated coordinates are rounded half up and saturated to the Q16.16 range.
module axis_rotation_3d (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic signed [15:0]  in_angle,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic signed [31:0]  in_coord_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_rot_x,
  output logic signed [31:0]  out_rot_y,
  output logic signed [31:0]  out_rot_z
);
  import axrot_pkg::*;

  // round-shifted sum down to Q16.16, clamped
  function automatic logic signed [31:0] sat32(input logic signed [64:0] a);
    logic signed [34:0] t;
    logic signed [31:0] v;
    begin
      t = a[64:30];
      if (t > 35'sd2147483647) begin
        v = 32'sh7fffffff;
      end else if (t < -35'sd2147483648) begin
        v = 32'sh80000000;
      end else begin
        v = t[31:0];
      end
      return v;
    end
  endfunction

  localparam logic signed [64:0] RND = 65'sd536870912;  // half an LSB after >> 30

  logic               en;
  side_t              in_side;

  logic               c_vld;
  logic signed [31:0] c_cos, c_sin;
  side_t              c_side;

  // multiply stage
  logic signed [31:0] u_sel, v_sel;
  logic signed [63:0] m_uc_r, m_vs_r, m_vc_r, m_us_r;
  side_t              m_side_r;
  logic               m_vld_r;

  // sum stage
  logic signed [64:0] s_u_r, s_v_r;
  side_t              s_side_r;
  logic               s_vld_r;

  // saturate stage
  vtx_t               fin_nxt;
  vtx_t               fin_r;
  logic               fin_vld_r;
  logic signed [31:0] u_sat, v_sat;

  // output register and skid
  vtx_t               out_r, skid_r;
  logic               out_valid_r, skid_full_r;
  logic               out_free, fin_go;

  // the whole pipe moves unless the skid entry is occupied
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  always_comb begin
    in_side.action = in_action;
    in_side.vtx.x  = in_coord_x;
    in_side.vtx.y  = in_coord_y;
    in_side.vtx.z  = in_coord_z;
  end

  axrot_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_angle  (in_angle),
    .in_side   (in_side),
    .out_valid (c_vld),
    .out_cos   (c_cos),
    .out_sin   (c_sin),
    .out_side  (c_side)
  );

  // pick the pair off the chosen axis: u' = u*c - v*s, v' = v*c + u*s
  always_comb begin
    unique case (c_side.action)
      ACT_ROLL: begin
        u_sel = c_side.vtx.y;
        v_sel = c_side.vtx.z;
      end
      ACT_PITCH: begin
        u_sel = c_side.vtx.x;
        v_sel = c_side.vtx.z;
      end
      default: begin  // yaw; pass-through ignores the products
        u_sel = c_side.vtx.x;
        v_sel = c_side.vtx.y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_uc_r   <= u_sel * c_cos;
      m_vs_r   <= v_sel * c_sin;
      m_vc_r   <= v_sel * c_cos;
      m_us_r   <= u_sel * c_sin;
      m_side_r <= c_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_u_r    <= 65'(m_uc_r) - 65'(m_vs_r) + RND;
      s_v_r    <= 65'(m_vc_r) + 65'(m_us_r) + RND;
      s_side_r <= m_side_r;
    end
  end

  assign u_sat = sat32(s_u_r);
  assign v_sat = sat32(s_v_r);

  // write the rotated pair back; the axis coordinate rides through
  always_comb begin
    fin_nxt = s_side_r.vtx;
    unique case (s_side_r.action)
      ACT_ROLL: begin
        fin_nxt.y = u_sat;
        fin_nxt.z = v_sat;
      end
      ACT_PITCH: begin
        fin_nxt.x = u_sat;
        fin_nxt.z = v_sat;
      end
      ACT_YAW: begin
        fin_nxt.x = u_sat;
        fin_nxt.y = v_sat;
      end
      default: begin
        fin_nxt = s_side_r.vtx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      s_vld_r   <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r   <= c_vld;
      s_vld_r   <= m_vld_r;
      fin_vld_r <= s_vld_r;
    end
  end

  // output register with one-entry skid
  assign out_free = !out_valid_r || !out_stall;
  assign fin_go   = fin_vld_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= skid_full_r || fin_go;
      skid_full_r <= 1'b0;
    end else if (fin_go) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_full_r ? skid_r : fin_r;
    end else if (fin_go) begin
      skid_r <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rot_x = out_r.x;
  assign out_rot_y = out_r.y;
  assign out_rot_z = out_r.z;

`ifndef SYNTH
  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with an empty output register");

  a_roll_keeps_x: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s_vld_r && s_side_r.action == ACT_ROLL) |=> fin_r.x == $past(s_side_r.vtx.x))
    else $error("roll changed the x coordinate");

  a_yaw_keeps_z: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s_vld_r && s_side_r.action == ACT_YAW) |=> fin_r.z == $past(s_side_r.vtx.z))
    else $error("yaw changed the z coordinate");

  a_none_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s_vld_r && s_side_r.action == ACT_NONE) |=> fin_r == $past(s_side_r.vtx))
    else $error("unused axis code altered the vertex");
`endif

endmodule

/* design/axrot_cordic.sv */
// axrot_cordic: pipelined sine/cosine of the negated angle, one CORDIC iteration per stage.
// Depends on axrot_pkg; carries the vertex alongside as sideband.
module axrot_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [15:0]   in_angle,
  input  axrot_pkg::side_t     in_side,
  output logic                 out_valid,
  output logic signed [31:0]   out_cos,
  output logic signed [31:0]   out_sin,
  output axrot_pkg::side_t     out_side
);
  import axrot_pkg::*;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         q;
  } crd_t;

  localparam int NStg = CordicStages + 1;  // fold stage plus iterations

  crd_t               st_r   [NStg];
  side_t              side_r [NStg];
  logic [NStg-1:0]    vld_r;

  logic [15:0]        ph;
  logic [15:0]        phq;
  logic [1:0]         r_hi;
  crd_t               fold_nxt;

  logic signed [31:0] cos_r, sin_r;
  logic signed [31:0] cos_nxt, sin_nxt;
  side_t              uside_r;
  logic               uvld_r;

  // quadrant fold: residual kept within +-pi/4
  always_comb begin
    ph         = 16'(-in_angle);
    phq        = ph + 16'h2000;
    r_hi       = ph[15:14] - phq[15:14];
    fold_nxt.x = CORDIC_ONE;
    fold_nxt.y = '0;
    fold_nxt.z = {r_hi, ph[13:0], 16'h0000};
    fold_nxt.q = phq[15:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= fold_nxt;
      side_r[0] <= in_side;
    end
  end

  genvar g;
  generate
    for (g = 1; g < NStg; g++) begin : g_iter
      logic signed [32:0] dx, dy;
      crd_t               st_nxt;
      always_comb begin
        dx     = st_r[g-1].y >>> (g - 1);
        dy     = st_r[g-1].x >>> (g - 1);
        st_nxt = st_r[g-1];
        if (!st_r[g-1].z[31]) begin
          st_nxt.x = st_r[g-1].x - dx;
          st_nxt.y = st_r[g-1].y + dy;
          st_nxt.z = st_r[g-1].z - atan_lut(g - 1);
        end else begin
          st_nxt.x = st_r[g-1].x + dx;
          st_nxt.y = st_r[g-1].y - dy;
          st_nxt.z = st_r[g-1].z + atan_lut(g - 1);
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[g]   <= st_nxt;
          side_r[g] <= side_r[g-1];
        end
      end
    end
  endgenerate

  // quadrant unfold
  always_comb begin
    unique case (st_r[NStg-1].q)
      2'd0: begin
        cos_nxt = 32'(st_r[NStg-1].x);
        sin_nxt = 32'(st_r[NStg-1].y);
      end
      2'd1: begin
        cos_nxt = 32'(-st_r[NStg-1].y);
        sin_nxt = 32'(st_r[NStg-1].x);
      end
      2'd2: begin
        cos_nxt = 32'(-st_r[NStg-1].x);
        sin_nxt = 32'(-st_r[NStg-1].y);
      end
      default: begin
        cos_nxt = 32'(st_r[NStg-1].y);
        sin_nxt = 32'(-st_r[NStg-1].x);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r   <= cos_nxt;
      sin_r   <= sin_nxt;
      uside_r <= side_r[NStg-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      uvld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[NStg-2:0], in_valid};
      uvld_r <= vld_r[NStg-1];
    end
  end

  assign out_valid = uvld_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;
  assign out_side  = uside_r;

`ifndef SYNTH
  a_resid_small: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NStg-1] |-> (st_r[NStg-1].z < 32'sd4096 && st_r[NStg-1].z > -32'sd4096))
    else $error("cordic residual angle did not converge");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    uvld_r |-> (cos_r <= 32'sd1090519040 && cos_r >= -32'sd1090519040 &&
                sin_r <= 32'sd1090519040 && sin_r >= -32'sd1090519040))
    else $error("sine or cosine out of unit range");
`endif

endmodule
